### sv/rsg_pkg.sv
// ----------------------------------------------------------------------------
// rsg_pkg
// Shared types, constants and helpers for the random interval stereo gate.
// ----------------------------------------------------------------------------
package rsg_pkg;

	// default parameter values
	localparam int SAMPLE_BITS_DEF = 24;
	localparam int COUNT_BITS_DEF  = 24;

	// fixed register and field widths
	localparam int LEN_W      = 24;
	localparam int STEP_W     = 16;
	localparam int SEED_W     = 32;
	localparam int GAIN_W     = 16;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 32;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_SILENCE  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_OPEN_MIN = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_OPEN_MAX = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_STEP     = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_SEED     = 3'd4;

	// register reset values
	localparam logic [LEN_W-1:0]  SILENCE_RST  = 24'd96000;
	localparam logic [LEN_W-1:0]  OPEN_MIN_RST = 24'd4800;
	localparam logic [LEN_W-1:0]  OPEN_MAX_RST = 24'd240000;
	localparam logic [STEP_W-1:0] STEP_RST     = 16'd68;
	localparam logic [SEED_W-1:0] SEED_RST     = 32'd44257;

	// gain in Q1.15, unity is 1.0
	localparam logic [GAIN_W-1:0] UNITY_GAIN = 16'd32768;

	// x^32 + x^22 + x^2 + x + 1, right-shifting galois form
	localparam logic [SEED_W-1:0] LFSR_TAPS = 32'h8020_0003;

	// gate state handed from the control stage to the scaling stage
	typedef struct packed {
		logic              gate_open;
		logic [GAIN_W-1:0] gain;
	} rsg_gate_t;

	// one step of the galois lfsr
	function automatic logic [SEED_W-1:0] lfsr_next(input logic [SEED_W-1:0] cur);
		logic [SEED_W-1:0] shifted;
		shifted = cur >> 1;
		return cur[0] ? (shifted ^ LFSR_TAPS) : shifted;
	endfunction

endpackage

### sv/rsg_ctrl.sv
// ----------------------------------------------------------------------------
// rsg_ctrl
// Configuration registers, span counter, LFSR draw and gain ramp. The span
// counter, mode and gain move forward by one sample on each accepted beat.
// ----------------------------------------------------------------------------
module rsg_ctrl import rsg_pkg::*; #(
	parameter int COUNT_BITS = COUNT_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_wr_en,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  step,
	output rsg_gate_t             gate
);

	logic [LEN_W-1:0]      silence_q;
	logic [LEN_W-1:0]      open_min_q;
	logic [LEN_W-1:0]      open_max_q;
	logic [STEP_W-1:0]     step_q;
	logic [SEED_W-1:0]     lfsr_q;
	logic [COUNT_BITS-1:0] left_q;
	logic                  mode_q;
	logic [GAIN_W-1:0]     gain_q;

	logic [SEED_W-1:0]       lfsr_adv;
	logic [LEN_W-1:0]        open_hi;
	logic [LEN_W:0]          span;
	logic [SEED_W+LEN_W:0]   draw_prod;
	logic [LEN_W:0]          draw_len;
	logic                    span_done;
	logic                    mode_nx;
	logic [COUNT_BITS-1:0]   load_len;
	logic [COUNT_BITS-1:0]   left_nx;
	logic [GAIN_W:0]         gain_ext;
	logic [GAIN_W:0]         step_ext;
	logic [GAIN_W:0]         target;
	logic [GAIN_W:0]         gain_up;
	logic [GAIN_W:0]         gain_nx;

	// random open length: min + floor(lfsr * span / 2^32)
	assign lfsr_adv  = lfsr_next(lfsr_q);
	assign open_hi   = (open_max_q < open_min_q) ? open_min_q : open_max_q;
	assign span      = {1'b0, open_hi} - {1'b0, open_min_q} + (LEN_W+1)'(1);
	assign draw_prod = (SEED_W+LEN_W+1)'(lfsr_adv) * (SEED_W+LEN_W+1)'(span);
	assign draw_len  = (LEN_W+1)'(open_min_q) + draw_prod[SEED_W+LEN_W:SEED_W];

	// mode toggle and counter reload when a span runs out
	always_comb begin
		span_done = (left_q == '0);
		mode_nx   = span_done ? ~mode_q : mode_q;
		if (!span_done) begin
			load_len = left_q;
		end else if (mode_q) begin
			load_len = COUNT_BITS'(silence_q);
		end else begin
			load_len = COUNT_BITS'(draw_len);
		end
		left_nx = (load_len != '0) ? load_len - COUNT_BITS'(1) : load_len;
	end

	// gain ramp toward the goal of the new mode, clamped at the goal
	always_comb begin
		gain_ext = {1'b0, gain_q};
		step_ext = (GAIN_W+1)'(step_q);
		target   = mode_nx ? (GAIN_W+1)'(UNITY_GAIN) : '0;
		gain_up  = gain_ext + step_ext;
		if (gain_ext < target) begin
			gain_nx = (gain_up > target) ? target : gain_up;
		end else if (gain_ext > target) begin
			gain_nx = ((gain_ext - target) > step_ext) ? (gain_ext - step_ext) : target;
		end else begin
			gain_nx = gain_ext;
		end
	end

	// configuration registers and lfsr
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			silence_q  <= SILENCE_RST;
			open_min_q <= OPEN_MIN_RST;
			open_max_q <= OPEN_MAX_RST;
			step_q     <= STEP_RST;
			lfsr_q     <= SEED_RST;
		end else begin
			if (cfg_wr_en) begin
				case (cfg_index)
					REG_SILENCE:  silence_q  <= cfg_data[LEN_W-1:0];
					REG_OPEN_MIN: open_min_q <= cfg_data[LEN_W-1:0];
					REG_OPEN_MAX: open_max_q <= cfg_data[LEN_W-1:0];
					REG_STEP:     step_q     <= cfg_data[STEP_W-1:0];
					REG_SEED: begin
						lfsr_q <= (cfg_data[SEED_W-1:0] == '0) ? SEED_W'(1) : cfg_data[SEED_W-1:0];
					end
					default: ;
				endcase
			end else if (step && span_done && !mode_q) begin
				lfsr_q <= lfsr_adv;
			end
		end
	end

	// span counter, mode and gain; goal always follows the mode once stepped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_q <= '0;
			mode_q <= 1'b0;
			gain_q <= UNITY_GAIN;
		end else if (step) begin
			left_q <= left_nx;
			mode_q <= mode_nx;
			gain_q <= gain_nx[GAIN_W-1:0];
		end
	end

	assign gate.gate_open = mode_q;
	assign gate.gain      = gain_q;

endmodule

### sv/rsg_scale.sv
// ----------------------------------------------------------------------------
// rsg_scale
// Multiplies both channels by the Q1.15 gain and registers the result beat.
// ----------------------------------------------------------------------------
module rsg_scale import rsg_pkg::*; #(
	parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          load,
	input  logic signed [SAMPLE_BITS-1:0] left_s1,
	input  logic signed [SAMPLE_BITS-1:0] right_s1,
	input  rsg_gate_t                     gate_s1,
	output logic signed [SAMPLE_BITS-1:0] left_s2,
	output logic signed [SAMPLE_BITS-1:0] right_s2,
	output logic                          gate_open_s2,
	output logic [GAIN_W-1:0]             gain_s2
);

	localparam int PROD_W = SAMPLE_BITS + GAIN_W + 1;

	logic signed [GAIN_W:0]   gain_sgn;
	logic signed [PROD_W-1:0] left_prod;
	logic signed [PROD_W-1:0] right_prod;

	// sample times gain, then floor shift by fifteen
	assign gain_sgn   = $signed({1'b0, gate_s1.gain});
	assign left_prod  = PROD_W'(left_s1) * PROD_W'(gain_sgn);
	assign right_prod = PROD_W'(right_s1) * PROD_W'(gain_sgn);

	// result register
	always_ff @(posedge clk) begin
		if (load) begin
			left_s2      <= left_prod[SAMPLE_BITS+14:15];
			right_s2     <= right_prod[SAMPLE_BITS+14:15];
			gate_open_s2 <= gate_s1.gate_open;
			gain_s2      <= gate_s1.gain;
		end
	end

endmodule

### sv/random_interval_stereo_gate_core.sv
// ----------------------------------------------------------------------------
// random_interval_stereo_gate_core
// Stereo gate that alternates fixed silent spans with random open spans and
// ramps a Q1.15 gain linearly between them.
// ----------------------------------------------------------------------------
// Takes one stereo pair per clock cycle while the output is not stalled and
// returns it through the input and result registers, scaled by the gain in
// force for that sample, with gate_open and gain_now alongside. The rate is
// set by the per-sample state loop (span counter, LFSR draw with its 32 x 25
// bit multiply, gain ramp); the sample multiply sits in a second stage behind
// it. The first pair after reset opens the gate. Register writes take effect
// at once; a seed write reloads the LFSR, with zero loaded as one.
module random_interval_stereo_gate_core import rsg_pkg::*; #(
	parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
	parameter int COUNT_BITS  = COUNT_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_wr_en,
	input  logic [CFG_IDX_W-1:0]          cfg_index,
	input  logic [CFG_DATA_W-1:0]         cfg_data,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic signed [SAMPLE_BITS-1:0] left_in,
	input  logic signed [SAMPLE_BITS-1:0] right_in,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic signed [SAMPLE_BITS-1:0] left_out,
	output logic signed [SAMPLE_BITS-1:0] right_out,
	output logic                          gate_open,
	output logic [GAIN_W-1:0]             gain_now
);

	logic                          valid_s1;
	logic                          valid_s2;
	logic                          adv_s2;
	logic                          in_beat;
	logic signed [SAMPLE_BITS-1:0] left_s1;
	logic signed [SAMPLE_BITS-1:0] right_s1;
	rsg_gate_t                     gate_s1;

	// pipeline flow control
	assign adv_s2    = !valid_s2 || out_ready;
	assign in_ready  = !valid_s1 || adv_s2;
	assign in_beat   = in_valid && in_ready;
	assign out_valid = valid_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (in_beat) begin
				valid_s1 <= 1'b1;
			end else if (adv_s2) begin
				valid_s1 <= 1'b0;
			end
			if (adv_s2) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	// input sample register
	always_ff @(posedge clk) begin
		if (in_beat) begin
			left_s1  <= left_in;
			right_s1 <= right_in;
		end
	end

	// gate state, stepped with each accepted beat
	rsg_ctrl #(
		.COUNT_BITS(COUNT_BITS)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.step      (in_beat),
		.gate      (gate_s1)
	);

	// gain multiply and result register
	rsg_scale #(
		.SAMPLE_BITS(SAMPLE_BITS)
	) u_scale (
		.clk          (clk),
		.load         (adv_s2 && valid_s1),
		.left_s1      (left_s1),
		.right_s1     (right_s1),
		.gate_s1      (gate_s1),
		.left_s2      (left_out),
		.right_s2     (right_out),
		.gate_open_s2 (gate_open),
		.gain_s2      (gain_now)
	);

endmodule

### verif/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the random interval stereo gate core.
// ----------------------------------------------------------------------------
// A cycle-free model of the gate (span counter, galois draw, gain ramp and
// Q1.15 scaling) runs on every accepted input beat and queues the expected
// output beat; every accepted output beat is checked field by field against
// the oldest entry. Directed cases cover the reset state and the corner
// settings, then randomized phases with fresh register settings run with
// bursty input, a stalling output side and one long output hold-off.
// ----------------------------------------------------------------------------
module tb_top;
	import rsg_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int SB = SAMPLE_BITS_DEF;
	localparam int CB = COUNT_BITS_DEF;

	// indexes past the register list, the block must ignore them
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

	localparam logic [SB-1:0] SAMPLE_MAX = {1'b0, {(SB-1){1'b1}}};
	localparam logic [SB-1:0] SAMPLE_MIN = {1'b1, {(SB-1){1'b0}}};

	typedef struct {
		logic signed [SB-1:0] left;
		logic signed [SB-1:0] right;
		logic                 open;
		logic [GAIN_W-1:0]    gain;
	} gate_beat_t;

	typedef enum int {READY_ALWAYS, READY_COIN, READY_EVERY_NTH} ready_mode_t;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  cfg_wr_en;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	logic                  in_valid;
	logic                  in_ready;
	logic signed [SB-1:0]  left_in;
	logic signed [SB-1:0]  right_in;
	logic                  out_valid;
	logic                  out_ready;
	logic signed [SB-1:0]  left_out;
	logic signed [SB-1:0]  right_out;
	logic                  gate_open;
	logic [GAIN_W-1:0]     gain_now;

	// gate model: registers and state
	logic [LEN_W-1:0]  silence_len = SILENCE_RST;
	logic [LEN_W-1:0]  open_min    = OPEN_MIN_RST;
	logic [LEN_W-1:0]  open_max    = OPEN_MAX_RST;
	int                ramp        = int'(STEP_RST);
	logic              gate_is_open = 1'b0;
	logic              heading_open = 1'b1;
	int                gain_lvl    = int'(UNITY_GAIN);
	logic [CB-1:0]     span_left   = '0;
	logic [SEED_W-1:0] lfsr_state  = SEED_RST;

	gate_beat_t expected_beats[$];
	int         fail_count = 0;
	int         shown_count = 0;
	int         hold_req = 0;

	random_interval_stereo_gate_core u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.left_in   (left_in),
		.right_in  (right_in),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.left_out  (left_out),
		.right_out (right_out),
		.gate_open (gate_open),
		.gain_now  (gain_now)
	);

	// clock
	initial begin
		forever #5 clk = ~clk;
	end

	// run limit
	initial begin
		#2_000_000;
		$display("tb_top failed");
		$finish;
	end

	function automatic void flag(string msg);
		fail_count++;
		if (shown_count < 10) begin
			shown_count++;
			$display("[%0t] %s", $time, msg);
		end
	endfunction

	// advance the model by one stereo pair and return the beat it should give
	function automatic gate_beat_t gate_sample(logic signed [SB-1:0] l, logic signed [SB-1:0] r);
		gate_beat_t res;
		longint unsigned hi_len;
		longint unsigned span;
		longint unsigned draw;
		longint          prod;
		int              target;
		// span expired: toggle the gate
		if (span_left == '0) begin
			if (gate_is_open) begin
				gate_is_open = 1'b0;
				heading_open = 1'b0;
				span_left = CB'(silence_len);
			end else begin
				gate_is_open = 1'b1;
				heading_open = 1'b1;
				lfsr_state = lfsr_state[0] ? ((lfsr_state >> 1) ^ LFSR_TAPS) : (lfsr_state >> 1);
				hi_len = 64'((open_max < open_min) ? open_min : open_max);
				span = hi_len - 64'(open_min) + 64'd1;
				draw = 64'(lfsr_state);
				draw = (draw * span) >> 32;
				span_left = CB'(64'(open_min) + draw);
			end
		end
		// linear ramp that stops at the goal
		target = heading_open ? int'(UNITY_GAIN) : 0;
		if (gain_lvl < target) begin
			gain_lvl += ramp;
			if (gain_lvl > target)
				gain_lvl = target;
		end else if (gain_lvl > target) begin
			gain_lvl = (gain_lvl - target > ramp) ? gain_lvl - ramp : target;
		end
		// scale with floor shift
		prod = longint'(l) * longint'(gain_lvl);
		res.left = SB'(prod >>> 15);
		prod = longint'(r) * longint'(gain_lvl);
		res.right = SB'(prod >>> 15);
		res.open = gate_is_open;
		res.gain = GAIN_W'(gain_lvl);
		if (span_left != '0)
			span_left--;
		return res;
	endfunction

	// input and output beat monitor
	always @(posedge clk) begin
		gate_beat_t want;
		if (arst_n === 1'b1) begin
			if (in_valid && in_ready)
				expected_beats.push_back(gate_sample(left_in, right_in));
			if (out_valid === 1'b1 && out_ready) begin
				if (expected_beats.size() == 0) begin
					flag("output beat with nothing expected");
				end else begin
					want = expected_beats.pop_front();
					if (left_out !== want.left)
						flag($sformatf("left_out: expected %0d, got %0d", want.left, left_out));
					if (right_out !== want.right)
						flag($sformatf("right_out: expected %0d, got %0d", want.right, right_out));
					if (gate_open !== want.open)
						flag($sformatf("gate_open: expected %0d, got %0d", want.open, gate_open));
					if (gain_now !== want.gain)
						flag($sformatf("gain_now: expected %0d, got %0d", want.gain, gain_now));
				end
			end
		end
	end

	// output side: random stall patterns plus requested long hold-offs
	initial begin
		ready_mode_t mode;
		int          stretch_left;
		int          nth;
		int          tick;
		int          hold_left;
		out_ready = 1'b0;
		mode = READY_ALWAYS;
		stretch_left = 0;
		nth = 2;
		tick = 0;
		hold_left = 0;
		wait (arst_n === 1'b1);
		forever begin
			@(negedge clk);
			if (hold_req > 0) begin
				hold_left = hold_req;
				hold_req = 0;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else begin
				if (stretch_left == 0) begin
					mode = ready_mode_t'($urandom_range(0, 2));
					stretch_left = $urandom_range(4, 60);
					nth = $urandom_range(2, 4);
					tick = 0;
				end
				stretch_left--;
				case (mode)
					READY_ALWAYS: out_ready <= 1'b1;
					READY_COIN: out_ready <= 1'($urandom_range(0, 1));
					default: begin
						out_ready <= (tick % nth == 0);
						tick++;
					end
				endcase
			end
		end
	end

	// one input beat; returns on the falling edge after acceptance, valid still high
	task automatic send_sample(input logic [SB-1:0] l, input logic [SB-1:0] r);
		in_valid <= 1'b1;
		left_in <= l;
		right_in <= r;
		do @(posedge clk); while (in_ready !== 1'b1);
		@(negedge clk);
	endtask

	task automatic sender_gap(input int n);
		in_valid <= 1'b0;
		repeat (n) @(negedge clk);
	endtask

	// stop sending and let every expected beat come out
	task automatic wait_idle();
		in_valid <= 1'b0;
		@(negedge clk);
		while (expected_beats.size() != 0)
			@(negedge clk);
	endtask

	// register write, mirrored into the model; leaves the enable high
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		case (idx)
			REG_SILENCE:  silence_len = data[LEN_W-1:0];
			REG_OPEN_MIN: open_min = data[LEN_W-1:0];
			REG_OPEN_MAX: open_max = data[LEN_W-1:0];
			REG_STEP:     ramp = int'(data[STEP_W-1:0]);
			REG_SEED:     lfsr_state = (data == '0) ? SEED_W'(1) : data;
			default: ;
		endcase
		@(negedge clk);
	endtask

	task automatic cfg_done();
		cfg_wr_en <= 1'b0;
		@(negedge clk);
	endtask

	task automatic apply_settings(input logic [CFG_DATA_W-1:0] sil, input logic [CFG_DATA_W-1:0] omin,
			input logic [CFG_DATA_W-1:0] omax, input logic [CFG_DATA_W-1:0] step,
			input logic [CFG_DATA_W-1:0] seed);
		write_reg(REG_SILENCE, sil);
		write_reg(REG_OPEN_MIN, omin);
		write_reg(REG_OPEN_MAX, omax);
		write_reg(REG_STEP, step);
		write_reg(REG_SEED, seed);
		cfg_done();
	endtask

	// full range samples with the extremes mixed in
	function automatic logic [SB-1:0] random_sample();
		case ($urandom_range(0, 15))
			0: return SAMPLE_MAX;
			1: return SAMPLE_MIN;
			2: return '0;
			3: return '1;
			default: return SB'($urandom);
		endcase
	endfunction

	// short spans so the gate keeps toggling; junk in the unused upper bits
	function automatic logic [CFG_DATA_W-1:0] pick_length();
		logic [LEN_W-1:0] len;
		case ($urandom_range(0, 19))
			0: len = '0;
			1, 2: len = LEN_W'($urandom_range(13, 40));
			default: len = LEN_W'($urandom_range(1, 12));
		endcase
		return {8'($urandom), len};
	endfunction

	function automatic logic [CFG_DATA_W-1:0] pick_step();
		logic [STEP_W-1:0] step;
		case ($urandom_range(0, 11))
			0: step = '0;
			1: step = STEP_W'(1);
			2: step = UNITY_GAIN;
			3: step = '1;
			4: step = STEP_W'($urandom);
			default: step = STEP_W'($urandom_range(2000, 20000));
		endcase
		return {16'($urandom), step};
	endfunction

	function automatic logic [CFG_DATA_W-1:0] pick_seed();
		return ($urandom_range(0, 5) == 0) ? '0 : CFG_DATA_W'($urandom);
	endfunction

	// reset seed and reset step, first beat opens the gate, a close ramps at the reset step
	task automatic test_reset_defaults();
		write_reg(REG_SILENCE, 32'd3);
		write_reg(REG_OPEN_MIN, 32'd2);
		write_reg(REG_OPEN_MAX, 32'd5);
		cfg_done();
		send_sample(SAMPLE_MAX, SAMPLE_MIN);
		send_sample(SAMPLE_MIN, SAMPLE_MAX);
		send_sample('0, '1);
		send_sample('1, '0);
		send_sample(SAMPLE_MAX, SAMPLE_MAX);
		send_sample(SAMPLE_MIN, SAMPLE_MIN);
		send_sample(SB'(1), random_sample());
		send_sample(random_sample(), SB'(1));
	endtask

	task automatic test_corner_settings();
		// zero seed loads one, maximum below minimum, step beyond unity
		wait_idle();
		apply_settings(32'd1, 32'd4, 32'd2, 32'h0000_FFFF, 32'd0);
		repeat (5) send_sample(SAMPLE_MAX, SAMPLE_MIN);
		// zero lengths toggle the gate on every sample
		wait_idle();
		write_reg(REG_SILENCE, 32'd0);
		write_reg(REG_OPEN_MIN, 32'd0);
		write_reg(REG_OPEN_MAX, 32'd0);
		write_reg(REG_STEP, 32'd16384);
		cfg_done();
		repeat (6) send_sample(SAMPLE_MIN, SAMPLE_MAX);
		// zero step holds the gain
		wait_idle();
		write_reg(REG_STEP, 32'd0);
		cfg_done();
		repeat (3) send_sample(random_sample(), random_sample());
		// writes past the register list change nothing
		wait_idle();
		write_reg(REG_SPARE_LO, CFG_DATA_W'($urandom));
		write_reg(REG_SPARE_HI, 32'hFFFF_FFFF);
		cfg_done();
		repeat (2) send_sample(random_sample(), random_sample());
	endtask

	task automatic test_random_phases();
		int burst_left;
		burst_left = 0;
		for (int ph = 0; ph < 10; ph++) begin
			wait_idle();
			apply_settings(pick_length(), pick_length(), pick_length(), pick_step(), pick_seed());
			for (int n = 0; n < 80; n++) begin
				if (burst_left == 0) begin
					burst_left = $urandom_range(1, 24);
					if ($urandom_range(0, 3) != 0)
						sender_gap($urandom_range(1, 6));
				end
				burst_left--;
				send_sample(random_sample(), random_sample());
			end
		end
	endtask

	// long output hold-off while input keeps coming, block must stall its input
	task automatic test_output_holdoff();
		wait_idle();
		apply_settings(32'd5, 32'd3, 32'd9, 32'd1024, CFG_DATA_W'($urandom));
		hold_req = 200;
		repeat (60) send_sample(random_sample(), random_sample());
	endtask

	// widest draw range, then the largest lengths; runs last since spans get huge
	task automatic test_extreme_lengths();
		wait_idle();
		apply_settings(32'd1, 32'd1, 32'h00FF_FFFF, 32'd1, 32'hFFFF_FFFF);
		for (int n = 0; n < 64 && !(gate_is_open && span_left > 1000); n++)
			send_sample(random_sample(), random_sample());
		wait_idle();
		write_reg(REG_SILENCE, 32'hFFFF_FFFF);
		write_reg(REG_OPEN_MIN, 32'hFFFF_FFFF);
		write_reg(REG_STEP, 32'hFFFF_FFFF);
		cfg_done();
		repeat (20) send_sample(random_sample(), random_sample());
	endtask

	// main sequence
	initial begin
		arst_n = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_index = REG_SILENCE;
		cfg_data = '0;
		in_valid = 1'b0;
		left_in = '0;
		right_in = '0;
		repeat (2) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_reset_defaults();
		test_corner_settings();
		test_random_phases();
		test_output_holdoff();
		test_extreme_lengths();

		// drain, then watch for stray beats
		in_valid <= 1'b0;
		for (int i = 0; i < 20000 && expected_beats.size() != 0; i++)
			@(negedge clk);
		repeat (20) @(negedge clk);
		if (expected_beats.size() != 0)
			flag($sformatf("%0d expected beats never came out", expected_beats.size()));

		if (fail_count == 0)
			$display("tb_top passed");
		else
			$display("tb_top failed");
		$finish;
	end

endmodule
